// ===== design/sdspi_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the SD SPI-mode command engine.
// No dependencies; imported by the engine, the top level and the checker.
package sdspi_pkg;

    // Item kinds on the slave side (tuser)
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Result kinds on the master side (tuser)
    localparam logic KIND_REQ  = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam int unsigned  RESPONSE_POLLS  = 10;
    localparam int unsigned  CNT_W           = 4;
    localparam logic [15:0]  TIMEOUT_RESET   = 16'd1000;

    localparam logic [7:0]   BYTE_IDLE       = 8'hFF;
    localparam logic [7:0]   CMD_START_BITS  = 8'h40;
    localparam logic [7:0]   CRC_CMD0        = 8'h95;
    localparam logic [7:0]   CRC_CMD8        = 8'h87;
    localparam logic [7:0]   CRC_OTHER       = 8'h01;
    localparam logic [5:0]   CMD_GO_IDLE     = 6'd0;
    localparam logic [5:0]   CMD_IF_COND     = 6'd8;
    localparam logic [5:0]   CMD_STOP_TRAN   = 6'd12;
    localparam logic [5:0]   CMD_APP_CMD     = 6'd55;

    localparam int unsigned  IN_DATA_W       = 48;
    localparam int unsigned  OUT_DATA_W      = 24;

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  cmd_index;
        logic        app_command;
        logic [31:0] argument;
        logic [7:0]  rx_byte;
    } t_item;

    // first member lands in the high bits: listed high to low
    typedef struct packed {
        logic [7:0] response;
        logic [7:0] tx_byte;
        logic       chip_select_low;
    } t_result;

endpackage

// ===== design/sdspi_engine.sv =====
`timescale 1ns / 1ps
// Command sequencer: state registers, single-pass next-state logic, result register.
// Depends on sdspi_pkg.
module sdspi_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_take,
    input  sdspi_pkg::t_item i_item,
    input  logic [15:0]      i_timeout,
    output logic             o_res_valid,
    output logic             o_res_kind,
    output sdspi_pkg::t_result o_res
);
    import sdspi_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_DESEL, PH_SEL, PH_WAIT, PH_TOUT, PH_SEND, PH_POLL
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [5:0]       r_index, n_index;
    logic [31:0]      r_arg,   n_arg;
    logic             r_app,   n_app;
    logic [15:0]      r_elapsed, n_elapsed;
    logic             r_cs_low, n_cs_low;
    logic             r_out_valid, n_out_valid;
    logic             r_out_kind, n_out_kind;
    t_result          r_out, n_out;

    function automatic logic [7:0] cmd_byte(input logic [CNT_W-1:0] c,
                                            input logic [5:0] idx,
                                            input logic [31:0] arg);
        logic [7:0] b;
        case (c)
            4'd0:    b = CMD_START_BITS | {2'b00, idx};
            4'd1:    b = arg[31:24];
            4'd2:    b = arg[23:16];
            4'd3:    b = arg[15:8];
            4'd4:    b = arg[7:0];
            4'd5:    b = (idx == CMD_GO_IDLE) ? CRC_CMD0 :
                         (idx == CMD_IF_COND) ? CRC_CMD8 : CRC_OTHER;
            default: b = BYTE_IDLE;
        endcase
        return b;
    endfunction

    logic             emit, done, begin_cmd;
    logic [7:0]       tx, resp;
    logic [5:0]       cur_idx, beg_idx;
    logic [31:0]      cur_arg;
    logic [CNT_W-1:0] poll_cnt, last_cnt;

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_index   = r_index;
        n_arg     = r_arg;
        n_app     = r_app;
        n_elapsed = r_elapsed;
        n_cs_low  = r_cs_low;
        emit      = 1'b0;
        done      = 1'b0;
        begin_cmd = 1'b0;
        tx        = BYTE_IDLE;
        resp      = 8'h00;
        cur_idx   = r_app ? CMD_APP_CMD : r_index;
        cur_arg   = r_app ? 32'd0 : r_arg;
        poll_cnt  = r_count + 1'b1;
        last_cnt  = (cur_idx == CMD_STOP_TRAN) ? 4'd6 : 4'd5;

        case (i_item.op)
            OP_START: begin
                if (r_phase == PH_IDLE) begin
                    n_index   = i_item.cmd_index;
                    n_arg     = i_item.argument;
                    n_app     = i_item.app_command;
                    begin_cmd = 1'b1;
                end
            end
            OP_TICK: begin
                if (r_phase != PH_IDLE && r_elapsed != 16'hFFFF)
                    n_elapsed = r_elapsed + 16'd1;
            end
            OP_BYTE: begin
                case (r_phase)
                    PH_DESEL: begin
                        n_phase  = PH_SEL;
                        n_cs_low = 1'b1;
                        emit     = 1'b1;
                    end
                    PH_SEL: begin
                        n_phase   = PH_WAIT;
                        n_elapsed = 16'd0;
                        emit      = 1'b1;
                    end
                    PH_WAIT: begin
                        emit = 1'b1;
                        if (i_item.rx_byte == BYTE_IDLE) begin
                            n_phase = PH_SEND;
                            n_count = '0;
                            tx      = cmd_byte('0, cur_idx, cur_arg);
                        end else if (r_elapsed >= i_timeout) begin
                            n_phase  = PH_TOUT;
                            n_cs_low = 1'b0;
                        end
                    end
                    PH_TOUT: begin
                        done = 1'b1;
                        resp = BYTE_IDLE;
                    end
                    PH_SEND: begin
                        emit = 1'b1;
                        if (r_count < last_cnt) begin
                            n_count = poll_cnt;
                            tx      = cmd_byte(poll_cnt, cur_idx, cur_arg);
                        end else begin
                            n_phase = PH_POLL;
                            n_count = '0;
                        end
                    end
                    PH_POLL: begin
                        n_count = poll_cnt;
                        if (i_item.rx_byte[7] && poll_cnt < CNT_W'(RESPONSE_POLLS)) begin
                            emit = 1'b1;
                        end else if (r_app && i_item.rx_byte <= 8'd1) begin
                            n_app     = 1'b0;
                            begin_cmd = 1'b1;
                        end else begin
                            done = 1'b1;
                            resp = i_item.rx_byte;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        // command opening: CMD12 skips the deselect/select/ready stages
        beg_idx = n_app ? CMD_APP_CMD : n_index;
        if (begin_cmd) begin
            emit = 1'b1;
            if (beg_idx == CMD_STOP_TRAN) begin
                n_phase = PH_SEND;
                n_count = '0;
                tx      = cmd_byte('0, beg_idx, 32'd0);
            end else begin
                n_phase  = PH_DESEL;
                n_cs_low = 1'b0;
                tx       = BYTE_IDLE;
            end
        end
        if (done) begin
            n_phase = PH_IDLE;
            n_count = '0;
            n_app   = 1'b0;
        end

        n_out_valid = emit | done;
        n_out_kind  = done ? KIND_DONE : KIND_REQ;
        n_out.chip_select_low = n_cs_low;
        n_out.tx_byte         = done ? 8'h00 : tx;
        n_out.response        = done ? resp : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_index     <= '0;
            r_arg       <= '0;
            r_app       <= 1'b0;
            r_elapsed   <= '0;
            r_cs_low    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_index     <= n_index;
            r_arg       <= n_arg;
            r_app       <= n_app;
            r_elapsed   <= n_elapsed;
            r_cs_low    <= n_cs_low;
            r_out_valid <= n_out_valid;
        end else if (i_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_out_kind <= n_out_kind;
            r_out      <= n_out;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res_kind  = r_out_kind;
    assign o_res       = r_out;

endmodule

// ===== design/sd_spi_command_transaction.sv =====
`timescale 1ns / 1ps
// Top level of the SD SPI-mode command engine: stream ports, input register, config.
// Depends on sdspi_pkg and sdspi_engine.
//
// Usage:
//  - Slave stream carries one beat per event: tuser is the op (start command,
//    byte received from the card, millisecond tick); tdata holds cmd_index,
//    app_command, argument and rx_byte.
//  - Master stream returns at most one beat per input beat: tuser = 0 asks the
//    SPI shifter to exchange tx_byte with CS at chip_select_low; tuser = 1
//    reports the finished command and its R1 response (0xFF when not ready).
//  - The caller feeds back each exchanged byte as a "byte received" beat.
//  - Path: an accepted beat is held in the input register, and its result is
//    loaded into the result register once that register is free or emptying,
//    which raises m_axis_tvalid.
//  - Throughput: one beat per cycle while results are taken; the whole step for a
//    beat is one pass of the next-state logic between the input and result registers.
//  - Stall: while a result waits unaccepted, the input register holds one more
//    beat, then s_axis_tready drops until the result beat is taken.
//  - Reset (synchronous, active low): engine idle, CS deselected, both
//    registers empty, ready timeout back to 1000 ms.
//  - Config: i_cfg_data sets the ready timeout in ms; write only while idle.
module sd_spi_command_transaction (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: cmd_index[5:0], app_command[6], argument[38:7], rx_byte[46:39], pad
    input  logic [sdspi_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: op[1:0]
    input  logic [1:0]                          s_axis_tuser,
    // master side
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: chip_select_low[0], tx_byte[8:1], response[16:9], pad
    output logic [sdspi_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // tuser: kind[0]
    output logic [0:0]                          m_axis_tuser,
    // config: ready timeout in ms
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [15:0]                         i_cfg_data
);
    import sdspi_pkg::*;

    logic        r_in_valid;
    t_item       r_in;
    logic [15:0] r_timeout;
    logic        step, take;
    logic        res_valid, res_kind;
    t_result     res;

    // input register advances whenever the result register is free or emptying
    assign step          = r_in_valid & (~res_valid | m_axis_tready);
    assign take          = res_valid & m_axis_tready;
    assign s_axis_tready = ~r_in_valid | step;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_timeout  <= TIMEOUT_RESET;
        end else begin
            if (s_axis_tready)
                r_in_valid <= s_axis_tvalid;
            if (i_cfg_valid)
                r_timeout <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.op          <= s_axis_tuser;
            r_in.cmd_index   <= s_axis_tdata[5:0];
            r_in.app_command <= s_axis_tdata[6];
            r_in.argument    <= s_axis_tdata[38:7];
            r_in.rx_byte     <= s_axis_tdata[46:39];
        end
    end

    sdspi_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_take      (take),
        .i_item      (r_in),
        .i_timeout   (r_timeout),
        .o_res_valid (res_valid),
        .o_res_kind  (res_kind),
        .o_res       (res)
    );

    assign m_axis_tvalid   = res_valid;
    assign m_axis_tuser[0] = res_kind;
    assign m_axis_tdata    = {{(OUT_DATA_W - $bits(t_result)){1'b0}}, res};

endmodule

// ===== design/sdspi_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the SD SPI command engine, bound to the top level.
// Depends on sdspi_pkg.
module sdspi_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [sdspi_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [0:0]                       m_axis_tuser
);
    import sdspi_pkg::*;

    // a stalled result beat is held
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped while stalled");

    // finish beats carry no transmit byte
    a_done_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] == KIND_DONE |-> m_axis_tdata[8:1] == 8'h00)
        else $error("finish beat with non-zero tx_byte");

    // exchange requests carry no response
    a_req_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] == KIND_REQ |-> m_axis_tdata[16:9] == 8'h00)
        else $error("request beat with non-zero response");

    // without an input beat, an empty result side stays empty
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tvalid && s_axis_tready) ##1 !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result beat without a causing input beat");

endmodule

bind sd_spi_command_transaction sdspi_checker u_sdspi_checker (.*);

// ===== test/sd_spi_command_transaction_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sd_spi_command_transaction: drives event beats, predicts each
// SPI exchange request and command completion, compares them beat by beat.
// Depends on sdspi_pkg and the RTL of the engine.
module sd_spi_command_transaction_tb;
    import sdspi_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;   // no meaning, engine drops it
    localparam int         STALL_LIMIT = 2000;   // cycles without any handshake
    localparam int         SETTLE_CYC  = 6;      // input reg + result reg, with margin

    typedef enum logic [2:0] {
        ST_IDLE, ST_DESEL, ST_SEL, ST_WAIT, ST_TOUT, ST_SEND, ST_POLL
    } t_eng_state;

    typedef struct packed {
        logic       kind;
        logic       cs_low;
        logic [7:0] tx_byte;
        logic [7:0] response;
    } t_spi_beat;

    // Mirror of the command engine plus the queue of result beats it owes.
    class command_scoreboard;
        t_eng_state  state;
        logic [3:0]  nbytes;
        logic [5:0]  cmd_idx;
        logic [31:0] cmd_arg;
        bit          prefix;       // CMD55 running ahead of an app command
        logic [15:0] elapsed;
        logic [7:0]  last_reply;
        bit          cs_low;
        logic [15:0] timeout_ms;
        t_spi_beat   pending_beats[$];
        int          errors;

        function new();
            state      = ST_IDLE;
            nbytes     = '0;
            cmd_idx    = '0;
            cmd_arg    = '0;
            prefix     = 1'b0;
            elapsed    = '0;
            last_reply = '0;
            cs_low     = 1'b0;
            timeout_ms = TIMEOUT_RESET;
            errors     = 0;
        endfunction

        function logic [5:0] active_idx();
            return prefix ? CMD_APP_CMD : cmd_idx;
        endfunction

        function logic [31:0] active_arg();
            return prefix ? 32'h0 : cmd_arg;
        endfunction

        function t_spi_beat exchange(logic [7:0] tx);
            return '{KIND_REQ, cs_low, tx, 8'h00};
        endfunction

        function t_spi_beat finish_cmd(logic [7:0] resp);
            last_reply = resp;
            state      = ST_IDLE;
            nbytes     = '0;
            prefix     = 1'b0;
            return '{KIND_DONE, cs_low, 8'h00, resp};
        endfunction

        // frame byte at position pos: start+index, argument MSB first, CRC, stuff
        function logic [7:0] frame_byte(int unsigned pos);
            logic [5:0]  idx;
            logic [31:0] arg;
            idx = active_idx();
            arg = active_arg();
            case (pos)
                0: return CMD_START_BITS | {2'b00, idx};
                1: return arg[31:24];
                2: return arg[23:16];
                3: return arg[15:8];
                4: return arg[7:0];
                5: return (idx == CMD_GO_IDLE) ? CRC_CMD0 :
                          (idx == CMD_IF_COND) ? CRC_CMD8 : CRC_OTHER;
                default: return BYTE_IDLE;
            endcase
        endfunction

        function t_spi_beat open_cmd();
            // stop transmission goes straight out, CS left as it is
            if (active_idx() == CMD_STOP_TRAN) begin
                state  = ST_SEND;
                nbytes = '0;
                return exchange(frame_byte(0));
            end
            state  = ST_DESEL;
            cs_low = 1'b0;
            return exchange(BYTE_IDLE);
        endfunction

        function bit engine_step(t_item it, output t_spi_beat r);
            logic [3:0] last_pos;
            r = '0;
            case (it.op)
                OP_START: begin
                    if (state != ST_IDLE) return 1'b0;
                    cmd_idx = it.cmd_index;
                    cmd_arg = it.argument;
                    prefix  = it.app_command;
                    r = open_cmd();
                    return 1'b1;
                end
                OP_TICK: begin
                    if (state != ST_IDLE && elapsed != 16'hFFFF) elapsed++;
                    return 1'b0;
                end
                OP_BYTE: ;
                default: return 1'b0;
            endcase
            case (state)
                ST_DESEL: begin
                    state  = ST_SEL;
                    cs_low = 1'b1;
                    r = exchange(BYTE_IDLE);
                end
                ST_SEL: begin
                    state   = ST_WAIT;
                    elapsed = '0;
                    r = exchange(BYTE_IDLE);
                end
                ST_WAIT: begin
                    if (it.rx_byte == BYTE_IDLE) begin
                        state  = ST_SEND;
                        nbytes = '0;
                        r = exchange(frame_byte(0));
                    end else if (elapsed >= timeout_ms) begin
                        state  = ST_TOUT;
                        cs_low = 1'b0;
                        r = exchange(BYTE_IDLE);
                    end else begin
                        r = exchange(BYTE_IDLE);
                    end
                end
                ST_TOUT: r = finish_cmd(BYTE_IDLE);
                ST_SEND: begin
                    last_pos = (active_idx() == CMD_STOP_TRAN) ? 4'd6 : 4'd5;
                    if (nbytes < last_pos) begin
                        nbytes++;
                        r = exchange(frame_byte(int'(nbytes)));
                    end else begin
                        state  = ST_POLL;
                        nbytes = '0;
                        r = exchange(BYTE_IDLE);
                    end
                end
                ST_POLL: begin
                    nbytes++;
                    if (it.rx_byte[7] && nbytes < RESPONSE_POLLS) begin
                        r = exchange(BYTE_IDLE);
                    end else if (prefix) begin
                        if (it.rx_byte > 8'd1) begin
                            r = finish_cmd(it.rx_byte);
                        end else begin
                            // CMD55 accepted: run the real command
                            last_reply = it.rx_byte;
                            prefix     = 1'b0;
                            r = open_cmd();
                        end
                    end else begin
                        r = finish_cmd(it.rx_byte);
                    end
                end
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function bit accept_event(t_item it);
            t_spi_beat r;
            if (!engine_step(it, r)) return 1'b0;
            pending_beats.push_back(r);
            return 1'b1;
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %02h got %02h", $time, name, want, got);
            end
        endfunction

        function void check_beat(t_spi_beat got);
            t_spi_beat want;
            if (pending_beats.size() == 0) begin
                errors++;
                $display("%0t: result beat expected none got %h", $time, got);
                return;
            end
            want = pending_beats.pop_front();
            compare_field("kind", {7'b0, want.kind}, {7'b0, got.kind});
            compare_field("chip_select_low", {7'b0, want.cs_low}, {7'b0, got.cs_low});
            compare_field("tx_byte", want.tx_byte, got.tx_byte);
            compare_field("response", want.response, got.response);
        endfunction

        function void check_leftovers();
            if (pending_beats.size() != 0) begin
                errors += pending_beats.size();
                $display("%0t: %0d beats owed, first expected %h got none", $time,
                         pending_beats.size(), pending_beats[0]);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [15:0]           i_cfg_data;

    command_scoreboard book;
    int unsigned       send_gap;   // percent of cycles the sender holds back
    int unsigned       recv_gap;   // percent of cycles the receiver stalls
    int                quiet;

    sd_spi_command_transaction dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            m_axis_tready <= ($urandom_range(0, 99) >= recv_gap);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            book.check_beat('{m_axis_tuser[0], m_axis_tdata[0], m_axis_tdata[8:1],
                              m_axis_tdata[16:9]});
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("sd_spi_command_transaction_tb: errors");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic t_item make_item(logic [1:0] op, logic [5:0] idx, logic app,
                                        logic [31:0] arg, logic [7:0] rx);
        t_item it;
        it.op          = op;
        it.cmd_index   = idx;
        it.app_command = app;
        it.argument    = arg;
        it.rx_byte     = rx;
        return it;
    endfunction

    // valid stays high after the beat; drain_results lowers it, the next call only while holding back
    task automatic push_item(input t_item it, output bit produced);
        while ($urandom_range(0, 99) < send_gap) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, it.rx_byte, it.argument, it.app_command, it.cmd_index};
        s_axis_tuser  <= it.op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        produced = book.accept_event(it);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (book.pending_beats.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_timeout(logic [15:0] ms);
        drain_results();
        repeat (SETTLE_CYC) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= ms;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        book.timeout_ms = ms;
    endtask

    // well-formed command: card ready at once, answers reply on the first poll
    task automatic walk_command(logic [5:0] idx, logic app, logic [31:0] arg,
                                logic [7:0] reply);
        bit produced;
        push_item(make_item(OP_START, idx, app, arg, 8'h00), produced);
        while (book.state != ST_IDLE)
            push_item(make_item(OP_BYTE, 6'($urandom), 1'($urandom), $urandom,
                                (book.state == ST_POLL) ? reply : BYTE_IDLE), produced);
    endtask

    // Mostly well-formed card dialogue steered by the predicted engine state.
    task automatic random_stretch(int target, bit storm_first);
        t_item       it;
        bit          produced;
        bit          storm;      // tick until the ready timeout expires
        bit          silent;     // card never answers the response poll
        bit          first;
        int unsigned extra;
        int unsigned pick;
        int          taken;
        taken  = 0;
        storm  = 1'b0;
        silent = 1'b0;
        first  = 1'b1;
        extra  = 0;
        while (taken < target || book.state != ST_IDLE) begin
            it = make_item(OP_BYTE, 6'($urandom), 1'($urandom), $urandom, 8'($urandom));
            pick = $urandom_range(0, 99);
            if (pick < 6 && !storm) begin
                case ($urandom_range(0, 2))
                    0: it.op = OP_TICK;
                    1: it.op = OP_UNUSED;
                    default: it.op = OP_START;
                endcase
            end else begin
                case (book.state)
                    ST_IDLE: begin
                        it.op = OP_START;
                        case ($urandom_range(0, 7))
                            0: it.cmd_index = CMD_GO_IDLE;
                            1: it.cmd_index = CMD_IF_COND;
                            2: it.cmd_index = CMD_STOP_TRAN;
                            3: it.cmd_index = CMD_APP_CMD;
                            default: ;
                        endcase
                        it.app_command = ($urandom_range(0, 99) < 30);
                        case ($urandom_range(0, 9))
                            0: it.argument = '0;
                            1: it.argument = '1;
                            default: ;
                        endcase
                        storm  = (first && storm_first) ||
                                 (book.timeout_ms <= 16'd16 && $urandom_range(0, 19) == 0);
                        silent = ($urandom_range(0, 9) == 0);
                        extra  = 3;
                        first  = 1'b0;
                    end
                    ST_WAIT: begin
                        if (storm) begin
                            if (book.elapsed < book.timeout_ms) begin
                                it.op = OP_TICK;
                            end else if (extra != 0) begin
                                // a few ticks past the limit
                                it.op = OP_TICK;
                                extra--;
                            end else begin
                                it.rx_byte = 8'($urandom_range(0, 254));
                                storm = 1'b0;
                            end
                        end else begin
                            pick = $urandom_range(0, 99);
                            if (pick < 40)      it.rx_byte = BYTE_IDLE;
                            else if (pick < 75) it.rx_byte = 8'($urandom_range(0, 254));
                            else                it.op = OP_TICK;
                        end
                    end
                    ST_POLL: begin
                        if (silent || $urandom_range(0, 99) < 55)
                            it.rx_byte[7] = 1'b1;
                        else if (book.prefix && $urandom_range(0, 3) != 0)
                            it.rx_byte = 8'($urandom_range(0, 1));
                        else
                            it.rx_byte[7] = 1'b0;
                    end
                    default: ;
                endcase
            end
            push_item(it, produced);
            if (produced) taken++;
        end
    endtask

    initial begin
        bit produced;
        book = new();
        send_gap = 24;
        recv_gap = 67;
        quiet    = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_START;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // stray beats while idle, then a plain CMD0 and a refused app command
        push_item(make_item(OP_BYTE, '1, 1'b1, '1, BYTE_IDLE), produced);
        push_item(make_item(OP_TICK, '0, 1'b0, '0, 8'h00), produced);
        push_item(make_item(OP_UNUSED, '1, 1'b1, '1, '1), produced);
        walk_command(CMD_GO_IDLE, 1'b0, 32'h0, 8'h01);
        walk_command(6'd41, 1'b1, 32'hFFFF_FFFF, 8'h05);

        // reset timeout first, then the extremes and a couple between
        random_stretch(360, 1'b0);
        write_timeout(16'd0);
        random_stretch(320, 1'b0);
        send_gap = 67;
        recv_gap = 24;
        write_timeout(16'd1);
        random_stretch(320, 1'b0);
        write_timeout(16'd7);
        random_stretch(320, 1'b1);
        send_gap = 0;
        recv_gap = 0;
        write_timeout(16'hFFFF);
        random_stretch(180, 1'b0);

        drain_results();
        repeat (SETTLE_CYC) @(posedge i_clk);
        book.check_leftovers();
        if (book.errors == 0) begin
            $display("sd_spi_command_transaction_tb: clean");
        end else begin
            $display("sd_spi_command_transaction_tb: errors");
        end
        $finish;
    end

endmodule
